>>> hdl/swde_pkg.sv
// Shared types and constants for the stereo width / delay enhancer.
// No dependencies; imported by swde_front, swde_back and the top level.
package swde_pkg;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam int unsigned GAIN_BITS      = 16;
    localparam int unsigned DELAY_REG_BITS = 12;
    localparam int unsigned DELAY_REG_MAX  = 4095;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_GAIN    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_LEN     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SURROUND_GAIN = 2'd2;

    localparam logic [GAIN_BITS-1:0]      GAIN_MAX            = 16'd32768;
    localparam logic [GAIN_BITS-1:0]      WIDTH_GAIN_RESET    = 16'd8192;
    localparam logic [GAIN_BITS-1:0]      SURROUND_GAIN_RESET = 16'd0;
    localparam logic [DELAY_REG_BITS-1:0] DELAY_LEN_RESET     = 12'd0;

    localparam int unsigned WIDTH_SHIFT    = 13;
    localparam int unsigned SURROUND_SHIFT = 15;

    typedef struct packed {
        logic                      surround;
        logic                      last;
        logic [GAIN_BITS-1:0]      wg;
        logic [GAIN_BITS-1:0]      sg;
        logic [DELAY_REG_BITS-1:0] delay;
    } desc_ctrl_t;

    localparam int unsigned CTRL_BITS = $bits(desc_ctrl_t);

    typedef struct packed {
        logic busy;
        logic out_load;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIDES,
        ST_MEM,
        ST_SCALE,
        ST_OUT
    } back_state_t;

endpackage

>>> hdl/swde_front.sv
// Front end: input handshake, gain/delay clamping, center and side differences.
// Depends on swde_pkg; feeds swde_fifo.
module swde_front #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned DELAY_DEPTH = 4096
) (
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [SAMPLE_BITS-1:0]          left_in,
    input  logic signed [SAMPLE_BITS-1:0]          right_in,
    input  logic                                   frame_last,
    input  logic [swde_pkg::GAIN_BITS-1:0]         width_gain,
    input  logic [swde_pkg::DELAY_REG_BITS-1:0]    delay_len,
    input  logic [swde_pkg::GAIN_BITS-1:0]         surround_gain,
    input  logic                                   fifo_full,
    output logic                                   fifo_push,
    output swde_pkg::desc_ctrl_t                   desc_ctrl,
    output logic signed [SAMPLE_BITS-1:0]          desc_c,
    output logic signed [SAMPLE_BITS:0]            desc_dl,
    output logic signed [SAMPLE_BITS:0]            desc_dr
);
    import swde_pkg::*;

    localparam int unsigned SB   = SAMPLE_BITS;
    localparam int unsigned DMAX = (DELAY_DEPTH - 1 > DELAY_REG_MAX) ?
                                   DELAY_REG_MAX : DELAY_DEPTH - 1;
    localparam logic [DELAY_REG_BITS-1:0] DMAX_R = DELAY_REG_BITS'(DMAX);

    logic signed [SB:0]   sum_lr;
    logic signed [SB:0]   half_lr;
    logic [GAIN_BITS-1:0] wg;
    logic [GAIN_BITS-1:0] sg;

    assign full      = fifo_full;
    assign fifo_push = push && !fifo_full;

    assign sum_lr  = (SB+1)'(left_in) + (SB+1)'(right_in);
    assign half_lr = sum_lr >>> 1;
    assign desc_c  = SB'(half_lr);
    assign desc_dl = (SB+1)'(left_in) - (SB+1)'(desc_c);
    assign desc_dr = (SB+1)'(right_in) - (SB+1)'(desc_c);

    assign wg = (width_gain > GAIN_MAX) ? GAIN_MAX : width_gain;
    assign sg = (surround_gain > GAIN_MAX) ? GAIN_MAX : surround_gain;

    always_comb
    begin
        desc_ctrl.surround = (sg != '0);
        desc_ctrl.last     = frame_last;
        desc_ctrl.wg       = wg;
        desc_ctrl.sg       = sg;
        desc_ctrl.delay    = (delay_len > DMAX_R) ? DMAX_R : delay_len;
    end

endmodule

>>> hdl/swde_fifo.sv
// Two-entry queue between front and back ends.
// Depends on nothing but its width parameter.
module swde_fifo #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    output logic [DATA_BITS-1:0] rd_data,
    output logic                 full,
    output logic                 empty
);

    logic [DATA_BITS-1:0] entry_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/swde_back.sv
// Back end: width products, delay memory access, surround mix, output register.
// Depends on swde_pkg; takes descriptors from swde_fifo.
module swde_back #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned DELAY_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fifo_empty,
    input  swde_pkg::desc_ctrl_t          head_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] head_c,
    input  logic signed [SAMPLE_BITS:0]   head_dl,
    input  logic signed [SAMPLE_BITS:0]   head_dr,
    output logic                          fifo_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic                          frame_last_out,
    output swde_pkg::back_status_t        stat
);
    import swde_pkg::*;

    localparam int unsigned SB  = SAMPLE_BITS;
    localparam int unsigned AW  = $clog2(DELAY_DEPTH);
    localparam int unsigned PW  = SB + 18;
    localparam int unsigned WW  = SB + 6;
    localparam int unsigned SPW = SB + 17;
    localparam logic signed [WW:0] SAT_HI = (WW+1)'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [WW:0] SAT_LO = -SAT_HI - (WW+1)'(1);
    localparam logic [AW-1:0]      WP_LAST = AW'(DELAY_DEPTH - 1);
    localparam logic [AW:0]        DEPTH_X = (AW+1)'(DELAY_DEPTH);

    function automatic logic signed [SB-1:0] sat_s(input logic signed [WW:0] x);
        logic signed [WW:0] y;
        begin
            y = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
            sat_s = SB'(y);
        end
    endfunction

    back_state_t state_reg;
    back_state_t state_next;

    desc_ctrl_t            ctrl_reg;
    logic signed [SB-1:0]  c_reg;
    logic signed [PW-1:0]  prod_l_reg;
    logic signed [PW-1:0]  prod_r_reg;
    logic signed [WW-1:0]  nl_reg;
    logic signed [WW-1:0]  nr_reg;
    logic [AW-1:0]         rp_reg;
    logic [AW-1:0]         wp_reg;
    logic                  wrapped_reg;
    logic signed [SB-1:0]  wdata_reg;
    logic                  fwd_reg;
    logic                  rd_valid_reg;
    logic signed [SB-1:0]  rdata_reg;
    logic signed [SB-1:0]  rdv_reg;
    logic signed [SPW-1:0] prod_s_reg;
    logic                  out_valid_reg;
    logic signed [SB-1:0]  left_reg;
    logic signed [SB-1:0]  right_reg;
    logic                  last_reg;

    logic signed [SB-1:0]  mem [DELAY_DEPTH];

    logic signed [16:0]    wg_s;
    logic signed [16:0]    sg_s;
    logic signed [PW-1:0]  pl;
    logic signed [PW-1:0]  pr;
    logic signed [PW-1:0]  pl_sh;
    logic signed [PW-1:0]  pr_sh;
    logic [AW:0]           rp_diff;
    logic [AW:0]           rp_wrap;
    logic [AW-1:0]         rp_calc;
    logic signed [WW:0]    side_sum;
    logic signed [WW:0]    side_half;
    logic signed [SB-1:0]  wval;
    logic signed [SB-1:0]  rdv;
    logic signed [SPW-1:0] ps;
    logic signed [SPW-1:0] ps_sh;
    logic signed [SB+1:0]  dlv;
    logic signed [WW:0]    lsum;
    logic signed [WW:0]    rsum;
    logic                  out_load;

    assign wg_s  = $signed({1'b0, head_ctrl.wg});
    assign pl    = head_dl * wg_s;
    assign pr    = head_dr * wg_s;
    assign pl_sh = prod_l_reg >>> WIDTH_SHIFT;
    assign pr_sh = prod_r_reg >>> WIDTH_SHIFT;

    assign rp_diff = {1'b0, wp_reg} - (AW+1)'(ctrl_reg.delay);
    assign rp_wrap = rp_diff + DEPTH_X;
    assign rp_calc = rp_diff[AW] ? rp_wrap[AW-1:0] : rp_diff[AW-1:0];

    assign side_sum  = (WW+1)'(nl_reg) + (WW+1)'(nr_reg);
    assign side_half = side_sum >>> 1;
    assign wval      = ctrl_reg.surround ? sat_s(side_half) : sat_s((WW+1)'(nr_reg));

    assign rdv   = fwd_reg ? wdata_reg : (rd_valid_reg ? rdata_reg : '0);
    assign sg_s  = $signed({1'b0, ctrl_reg.sg});
    assign ps    = rdv * sg_s;
    assign ps_sh = prod_s_reg >>> SURROUND_SHIFT;
    assign dlv   = (SB+2)'(ps_sh);
    assign lsum  = (WW+1)'(nl_reg) + (WW+1)'(dlv);
    assign rsum  = (WW+1)'(nr_reg) - (WW+1)'(dlv);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = ST_SIDES;
                end
            end
            ST_SIDES: state_next = ST_MEM;
            ST_MEM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        fifo_pop = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: fifo_pop = !fifo_empty;
            ST_OUT:  out_load = !out_valid_reg || pop;
            default:
            begin
                fifo_pop = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.out_load = out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MEM)
            begin
                if (wp_reg == WP_LAST)
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + AW'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            ctrl_reg   <= head_ctrl;
            c_reg      <= head_c;
            prod_l_reg <= pl;
            prod_r_reg <= pr;
        end
        if (state_reg == ST_SIDES)
        begin
            nl_reg <= WW'(c_reg) + WW'(pl_sh);
            nr_reg <= WW'(c_reg) + WW'(pr_sh);
            rp_reg <= rp_calc;
        end
        if (state_reg == ST_MEM)
        begin
            wdata_reg    <= wval;
            fwd_reg      <= (rp_reg == wp_reg);
            rd_valid_reg <= wrapped_reg || (rp_reg < wp_reg);
        end
        if (state_reg == ST_SCALE)
        begin
            rdv_reg    <= rdv;
            prod_s_reg <= ps;
        end
        if (out_load)
        begin
            left_reg  <= ctrl_reg.surround ? sat_s(lsum) : sat_s((WW+1)'(nl_reg));
            right_reg <= ctrl_reg.surround ? sat_s(rsum) : rdv_reg;
            last_reg  <= ctrl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MEM)
        begin
            mem[wp_reg] <= wval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MEM)
        begin
            rdata_reg <= mem[rp_reg];
        end
    end

    assign empty          = !out_valid_reg;
    assign left_out       = left_reg;
    assign right_out      = right_reg;
    assign frame_last_out = last_reg;

endmodule

>>> hdl/stereo_width_delay_enhancer_core.sv
// Top level of the stereo width / delay enhancer: config registers and the
// front end, queue and back end. Depends on swde_pkg, swde_front, swde_fifo, swde_back.
//
//   channel   signals                                   beat when
//   input     push/full, left_in, right_in, frame_last  push && !full
//   result    empty/pop, left_out, right_out,           pop && !empty
//             frame_last_out
//   config    cfg_we, cfg_index, cfg_data               cfg_we
//
// The back-end sequencer takes one frame at a time (width products, sides, delay
// memory write/read, surround product, output) and pops none until it is output.
// The front takes a beat whenever the 2-entry queue has room.
// After reset no memory clearing pass is run: a fill mark makes unwritten delay
// entries read as zero. A full output register stalls the back end, then the front.
module stereo_width_delay_enhancer_core #(
    parameter int unsigned DELAY_DEPTH = 4096,
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [SAMPLE_BITS-1:0]        left_in,
    input  logic signed [SAMPLE_BITS-1:0]        right_in,
    input  logic                                 frame_last,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [SAMPLE_BITS-1:0]        left_out,
    output logic signed [SAMPLE_BITS-1:0]        right_out,
    output logic                                 frame_last_out,
    input  logic                                 cfg_we,
    input  logic [swde_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [swde_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import swde_pkg::*;

    localparam int unsigned SB      = SAMPLE_BITS;
    localparam int unsigned Q_BITS  = CTRL_BITS + SB + 2 * (SB + 1);

    logic [GAIN_BITS-1:0]      width_gain_reg;
    logic [DELAY_REG_BITS-1:0] delay_len_reg;
    logic [GAIN_BITS-1:0]      surround_gain_reg;

    logic                 fifo_full;
    logic                 fifo_empty;
    logic                 fifo_push;
    logic                 fifo_pop;
    desc_ctrl_t           in_ctrl;
    logic signed [SB-1:0] in_c;
    logic signed [SB:0]   in_dl;
    logic signed [SB:0]   in_dr;
    logic [Q_BITS-1:0]    q_wr;
    logic [Q_BITS-1:0]    q_rd;
    desc_ctrl_t           head_ctrl;
    logic signed [SB-1:0] head_c;
    logic signed [SB:0]   head_dl;
    logic signed [SB:0]   head_dr;
    back_status_t         back_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_gain_reg    <= WIDTH_GAIN_RESET;
            delay_len_reg     <= DELAY_LEN_RESET;
            surround_gain_reg <= SURROUND_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH_GAIN:    width_gain_reg    <= cfg_data;
                CFG_DELAY_LEN:     delay_len_reg     <= cfg_data[DELAY_REG_BITS-1:0];
                CFG_SURROUND_GAIN: surround_gain_reg <= cfg_data;
                default:           width_gain_reg    <= width_gain_reg;
            endcase
        end
    end

    swde_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_front (
        .push          (push),
        .full          (full),
        .left_in       (left_in),
        .right_in      (right_in),
        .frame_last    (frame_last),
        .width_gain    (width_gain_reg),
        .delay_len     (delay_len_reg),
        .surround_gain (surround_gain_reg),
        .fifo_full     (fifo_full),
        .fifo_push     (fifo_push),
        .desc_ctrl     (in_ctrl),
        .desc_c        (in_c),
        .desc_dl       (in_dl),
        .desc_dr       (in_dr)
    );

    assign q_wr = {in_ctrl, in_c, in_dl, in_dr};

    swde_fifo #(
        .DATA_BITS (Q_BITS)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fifo_push),
        .wr_data (q_wr),
        .rd_en   (fifo_pop),
        .rd_data (q_rd),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    assign {head_ctrl, head_c, head_dl, head_dr} = q_rd;

    swde_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_empty     (fifo_empty),
        .head_ctrl      (head_ctrl),
        .head_c         (head_c),
        .head_dl        (head_dl),
        .head_dr        (head_dr),
        .fifo_pop       (fifo_pop),
        .pop            (pop),
        .empty          (empty),
        .left_out       (left_out),
        .right_out      (right_out),
        .frame_last_out (frame_last_out),
        .stat           (back_stat)
    );

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("queue popped while empty");

    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |=> back_stat.busy)
        else $error("back end idle after taking a descriptor");

    a_result_from_back: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(back_stat.out_load))
        else $error("result appeared without a back-end load");
`endif

endmodule
